// ===== design/sssp_pkg.sv =====
// Shared types and constants for the shortest path unit.
// No dependencies.
`default_nettype none
package sssp_pkg;
	localparam int NODES = 32;
	localparam int COST_BITS = 16;
	localparam int DIST_BITS = 24;
	localparam int NODE_W = $clog2(NODES);
	localparam int ARC_W = 2 * NODE_W;
	localparam int SLOTS = (NODES < 32) ? NODES : 32;
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_RUN = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [4:0]  src_node;
		logic [4:0]  dst_node;
		logic [15:0] arc_weight;
	} req_t;

	typedef struct packed {
		logic [4:0]  node_id;
		logic        node_present;
		logic        reachable;
		logic [23:0] distance;
		logic        has_predecessor;
		logic [4:0]  predecessor;
		logic        last;
	} res_t;
endpackage
`default_nettype wire

// ===== design/single_source_shortest_path_unit.sv =====
// Top level of the shortest path unit: arc store, Dijkstra sequencer, result stage.
// Depends on sssp_pkg.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | sssp_pkg::req_t
//  res     | out       | res_valid/res_stall | sssp_pkg::res_t
//
// After reset a clearing pass zeroes all NODES*NODES (1024) arc memory entries;
// req stalls until it ends.
// Add and remove read the arc memory entry, then write it in the update state.
// A run settles one node at a time before results:
// each settled node costs a minimum scan and a row walk,
// one arc memory read a cycle, and a last empty scan ends the search.
// Then NODES results are emitted, one a cycle when res is not stalled; req stalls
// until the last result is loaded into the output register.
`default_nettype none
module single_source_shortest_path_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire sssp_pkg::req_t req,
	output logic                res_valid,
	input  wire logic           res_stall,
	output sssp_pkg::res_t      res
);
	import sssp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_RLX  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam logic [2:0] ST_CLR  = 3'd5;
	localparam logic [DIST_BITS:0] DMAX = {1'b0, {DIST_BITS{1'b1}}};

	logic [2:0] state_q;
	logic [NODES-1:0] present_q, reach_q, settled_q, haspred_q;
	// arc memory entry: valid bit above the cost
	logic [COST_BITS:0] cost_mem [NODES*NODES];
	logic [COST_BITS:0] cost_rd_q;
	logic [DIST_BITS-1:0] dist_q [NODES];
	logic [NODE_W-1:0] pred_q [NODES];
	req_t req_q;
	logic [NODE_W:0] cnt_q;
	logic [ARC_W-1:0] clr_q;
	logic [NODE_W-1:0] u_q, best_q;
	logic found_q;
	logic [DIST_BITS-1:0] du_q;
	logic rd_v_s1;
	logic [NODE_W-1:0] rd_v_idx_s1;
	logic res_full_q;

	wire take = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	wire in_range_s = (32'(req.src_node) < NODES);
	wire in_range_d = (32'(req.dst_node) < NODES);
	wire [NODE_W-1:0] ns = req.src_node[NODE_W-1:0];
	wire [NODE_W-1:0] nd = req.dst_node[NODE_W-1:0];
	wire [NODE_W-1:0] rs = req_q.src_node[NODE_W-1:0];
	wire [NODE_W-1:0] rd = req_q.dst_node[NODE_W-1:0];
	wire [NODE_W-1:0] ci = cnt_q[NODE_W-1:0];
	wire [ARC_W-1:0] arc_a = {rs, rd};
	wire [ARC_W-1:0] row_a = {u_q, ci};
	wire [ARC_W-1:0] mem_ra = (state_q == ST_IDLE) ? {ns, nd} : row_a;
	wire res_load = (state_q == ST_OUT) && (!res_full_q || !res_stall);

	// relaxation sum for the column read last cycle
	wire [DIST_BITS:0] sum_w = {1'b0, du_q} + (DIST_BITS+1)'(cost_rd_q[COST_BITS-1:0]);
	wire [DIST_BITS-1:0] sum_c = (sum_w > DMAX) ? DMAX[DIST_BITS-1:0] : sum_w[DIST_BITS-1:0];

	always_ff @(posedge clk) begin
		if (state_q == ST_CLR)
			cost_mem[clr_q] <= '0;
		else if (state_q == ST_UPD &&
			(req_q.operation == OP_REMOVE || !cost_rd_q[COST_BITS]))
			cost_mem[arc_a] <= {req_q.operation == OP_ADD, req_q.arc_weight[COST_BITS-1:0]};
		cost_rd_q <= cost_mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			present_q <= '0;
			reach_q <= '0;
			settled_q <= '0;
			haspred_q <= '0;
			cnt_q <= '0;
			clr_q <= '0;
			found_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			res_full_q <= 1'b0;
		end else begin
			if (res_load) res_full_q <= 1'b1;
			else if (!res_stall) res_full_q <= 1'b0;
			rd_v_s1 <= (state_q == ST_RLX) && (cnt_q != (NODE_W+1)'(NODES));
			rd_v_idx_s1 <= ci;
			unique case (state_q)
				ST_CLR: begin
					if (clr_q == '1) state_q <= ST_IDLE;
					clr_q <= clr_q + 1'b1;
				end
				ST_IDLE: if (take) begin
					req_q <= req;
					if ((req.operation == OP_ADD || req.operation == OP_REMOVE)
						&& in_range_s && in_range_d)
						state_q <= ST_UPD;
					else if (req.operation == OP_RUN && in_range_s) begin
						reach_q <= NODES'(present_q[ns]) << ns;
						settled_q <= '0;
						haspred_q <= '0;
						dist_q[ns] <= '0;
						cnt_q <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_UPD: begin
					if (req_q.operation == OP_ADD) begin
						present_q[rs] <= 1'b1;
						present_q[rd] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (cnt_q == (NODE_W+1)'(NODES)) begin
						cnt_q <= '0;
						if (found_q) begin
							u_q <= best_q;
							du_q <= dist_q[best_q];
							settled_q[best_q] <= 1'b1;
							state_q <= ST_RLX;
						end else
							state_q <= ST_OUT;
					end else begin
						if (reach_q[ci] && !settled_q[ci] &&
							(!found_q || dist_q[ci] < dist_q[best_q])) begin
							best_q <= ci;
							found_q <= 1'b1;
						end
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RLX: begin
					// address column cnt this cycle; relax the previous one
					if (cnt_q != (NODE_W+1)'(NODES))
						cnt_q <= cnt_q + 1'b1;
					if (rd_v_s1 && cost_rd_q[COST_BITS] && present_q[rd_v_idx_s1] &&
						(!reach_q[rd_v_idx_s1] || sum_c < dist_q[rd_v_idx_s1])) begin
						reach_q[rd_v_idx_s1] <= 1'b1;
						dist_q[rd_v_idx_s1] <= sum_c;
						pred_q[rd_v_idx_s1] <= u_q;
						haspred_q[rd_v_idx_s1] <= 1'b1;
					end
					if (cnt_q == (NODE_W+1)'(NODES) && !rd_v_s1) begin
						cnt_q <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_OUT: if (res_load) begin
					res.node_id <= 5'(ci);
					res.node_present <= present_q[ci];
					res.reachable <= reach_q[ci];
					res.distance <= reach_q[ci] ? 24'(dist_q[ci]) : '0;
					res.has_predecessor <= reach_q[ci] && haspred_q[ci];
					res.predecessor <= (reach_q[ci] && haspred_q[ci]) ? 5'(pred_q[ci]) : '0;
					res.last <= (cnt_q == (NODE_W+1)'(SLOTS - 1));
					if (cnt_q == (NODE_W+1)'(SLOTS - 1)) state_q <= ST_IDLE;
					else cnt_q <= cnt_q + 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_full_q;
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for single_source_shortest_path_unit: arc adds, removes and runs
// checked against an in-bench Dijkstra predictor. Depends on sssp_pkg and the unit.
`default_nettype none
module tb;
	import sssp_pkg::*;

	localparam int LIMIT = 12000000;
	localparam int RING = 256;
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	single_source_shortest_path_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always #2 clk = ~clk;

	// predictor copy of the graph
	logic        present_q [SLOTS];
	logic        arc_on_q [SLOTS*SLOTS];
	logic [15:0] arc_cost_q [SLOTS*SLOTS];
	res_t        exp_ring [RING];
	int          exp_wr = 0;
	int          exp_rd = 0;

	int errors = 0;
	int cycles = 0;
	bit rx_quiet = 1'b0;
	bit hold_go = 1'b0;
	bit hold_armed = 1'b0;
	int hold_cnt = 0;
	int rx_gap = 0;

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic predict_shortest_paths(logic [4:0] s);
		logic [23:0] best_d [SLOTS];
		logic        reach [SLOTS];
		logic        done [SLOTS];
		logic [5:0]  pred [SLOTS];
		int u, sum;
		bit found;
		res_t r;
		for (int n = 0; n < SLOTS; n++) begin
			best_d[n] = '0; reach[n] = 1'b0; done[n] = 1'b0; pred[n] = 6'd63;
		end
		if (present_q[s]) begin
			reach[s] = 1'b1;
			forever begin
				found = 1'b0;
				u = 0;
				for (int n = 0; n < SLOTS; n++)
					if (present_q[n] && reach[n] && !done[n] &&
						(!found || best_d[n] < best_d[u])) begin
						u = n;
						found = 1'b1;
					end
				if (!found) break;
				done[u] = 1'b1;
				for (int v = 0; v < SLOTS; v++) begin
					if (!arc_on_q[u*SLOTS+v] || !present_q[v]) continue;
					sum = int'(best_d[u]) + int'(arc_cost_q[u*SLOTS+v]);
					if (sum > 24'hFFFFFF) sum = 24'hFFFFFF;
					if (!reach[v] || sum < int'(best_d[v])) begin
						reach[v] = 1'b1;
						best_d[v] = sum[23:0];
						pred[v] = 6'(u);
					end
				end
			end
		end
		for (int k = 0; k < SLOTS; k++) begin
			r.node_id = 5'(k);
			r.node_present = present_q[k];
			r.reachable = reach[k];
			r.distance = reach[k] ? best_d[k] : '0;
			r.has_predecessor = reach[k] && pred[k] != 6'd63;
			r.predecessor = r.has_predecessor ? pred[k][4:0] : '0;
			r.last = (k == SLOTS - 1);
			exp_ring[exp_wr % RING] = r;
			exp_wr++;
		end
	endtask

	task automatic apply_request(req_t r);
		int a;
		a = int'(r.src_node) * SLOTS + int'(r.dst_node);
		case (r.operation)
			OP_ADD: begin
				present_q[r.src_node] = 1'b1;
				present_q[r.dst_node] = 1'b1;
				if (!arc_on_q[a]) begin
					arc_on_q[a] = 1'b1;
					arc_cost_q[a] = r.arc_weight;
				end
			end
			OP_REMOVE: arc_on_q[a] = 1'b0;
			OP_RUN: predict_shortest_paths(r.src_node);
			default: ;
		endcase
	endtask

	// offer one request, hold it until taken, then, if idle is set, idle a random while
	task automatic send_request(req_t r, bit idle = 1'b1);
		int g;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		apply_request(r);
		g = idle ? gap_len() : 0;
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic req_t mk(logic [1:0] op, logic [4:0] s, logic [4:0] d, logic [15:0] w);
		req_t r;
		r.operation = op; r.src_node = s; r.dst_node = d; r.arc_weight = w;
		return r;
	endfunction

	task automatic drain();
		req_valid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic test_directed();
		send_request(mk(OP_RUN, 5'd0, 5'd0, 16'd0));          // empty graph
		send_request(mk(OP_ADD, 5'd0, 5'd31, 16'hFFFF));
		send_request(mk(OP_ADD, 5'd0, 5'd31, 16'd1));          // duplicate keeps first
		send_request(mk(OP_ADD, 5'd0, 5'd1, 16'd0));
		send_request(mk(OP_ADD, 5'd1, 5'd2, 16'd5));
		send_request(mk(OP_ADD, 5'd0, 5'd3, 16'd2));
		send_request(mk(OP_ADD, 5'd3, 5'd2, 16'd3));           // tie on node 2
		send_request(mk(OP_ADD, 5'd2, 5'd2, 16'd7));           // self loop
		send_request(mk(OP_RUN, 5'd0, 5'd31, 16'hFFFF));
		send_request(mk(OP_REMOVE, 5'd4, 5'd5, 16'hFFFF));     // missing arc
		send_request(mk(OP_REMOVE, 5'd0, 5'd31, 16'd0));
		send_request(mk(OP_SPARE, 5'd31, 5'd31, 16'hFFFF));
		send_request(mk(OP_RUN, 5'd31, 5'd0, 16'd0));
		send_request(mk(OP_RUN, 5'd10, 5'd0, 16'd0));          // source not present
		send_request(mk(OP_ADD, 5'd31, 5'd0, 16'h8000));
		send_request(mk(OP_RUN, 5'd0, 5'd0, 16'd0));
		send_request(mk(OP_RUN, 5'd31, 5'd0, 16'd0));
		drain();
	endtask

	task automatic test_random(int count);
		req_t r;
		int p;
		for (int i = 0; i < count; i++) begin
			p = $urandom_range(0, 99);
			r.src_node = $urandom_range(0, 99) < 70 ? 5'($urandom_range(0, 11)) : 5'($urandom());
			r.dst_node = $urandom_range(0, 99) < 70 ? 5'($urandom_range(0, 11)) : 5'($urandom());
			r.arc_weight = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 40));
			if (p < 55) r.operation = OP_ADD;
			else if (p < 75) r.operation = OP_REMOVE;
			else if (p < 95) r.operation = OP_RUN;
			else r.operation = OP_SPARE;
			if (i == count / 2) rx_quiet = 1'b1;
			if (i == count / 2 + 40) rx_quiet = 1'b0;
			send_request(r, i < count / 2 || i > count / 2 + 40);
		end
		drain();
	endtask

	// hold the result side off while several runs are offered back to back
	task automatic test_backpressure();
		hold_go = 1'b1;
		for (int i = 0; i < 6; i++)
			send_request(mk(OP_RUN, 5'($urandom_range(0, 11)), 5'($urandom()), 16'($urandom())), 1'b0);
		drain();
	endtask

	always @(posedge clk) begin
		if (hold_go && !hold_armed) begin
			hold_armed <= 1'b1;
			hold_cnt <= 6000;
			res_stall <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			res_stall <= 1'b1;
		end else if (rx_quiet) begin
			res_stall <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			res_stall <= 1'b1;
		end else begin
			rx_gap <= gap_len();
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (exp_wr == exp_rd) begin
				report("unexpected result node", res.node_id, -1);
			end else begin
				want = exp_ring[exp_rd % RING];
				exp_rd++;
				if (res.node_id !== want.node_id) report("node_id", res.node_id, want.node_id);
				if (res.node_present !== want.node_present)
					report("node_present", res.node_present, want.node_present);
				if (res.reachable !== want.reachable)
					report("reachable", res.reachable, want.reachable);
				if (res.distance !== want.distance) report("distance", res.distance, want.distance);
				if (res.has_predecessor !== want.has_predecessor)
					report("has_predecessor", res.has_predecessor, want.has_predecessor);
				if (res.predecessor !== want.predecessor)
					report("predecessor", res.predecessor, want.predecessor);
				if (res.last !== want.last) report("last", res.last, want.last);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		for (int n = 0; n < SLOTS; n++) present_q[n] = 1'b0;
		for (int a = 0; a < SLOTS*SLOTS; a++) begin
			arc_on_q[a] = 1'b0;
			arc_cost_q[a] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(480);
		test_backpressure();
		if (exp_wr != exp_rd)
			report("results never delivered", 0, exp_wr - exp_rd);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
design/sssp_pkg.sv
design/single_source_shortest_path_unit.sv
tb/tb.sv
